>>> rtl/core/apss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apss_pkg: shared types and constants of the heading-hold servo stepper
// Field widths, gain format, level quantizer constants and the servo table.
// ----------------------------------------------------------------------------
package apss_pkg;

	localparam int GAIN_FRAC_BITS = 8;

	localparam int HEAD_W  = 9;
	localparam int ERR_W   = 8;
	localparam int DIFF_W  = 10;
	localparam int TERM_W  = 10;
	localparam int INTEG_W = 15;
	localparam int SUM_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int PD_W    = GAIN_W + 1 + TERM_W;
	localparam int PI_W    = GAIN_W + 1 + INTEG_W;
	localparam int ACC_W   = PI_W + 1;
	localparam int LVL_W   = 3;
	localparam int IDX_W   = 4;

	localparam int FULL_TURN   = 360;
	localparam int HALF_TURN   = 180;
	localparam int FLIP_LIMIT  = 10000;
	localparam int INTEG_CLAMP = 16383;
	localparam int LEVEL_CAP   = 5;
	localparam int LEVEL_STEP  = 1000;

	localparam logic [ACC_W-1:0] LEVEL_UNIT = ACC_W'(LEVEL_STEP * (2 ** GAIN_FRAC_BITS));
	localparam logic [ACC_W-1:0] LEVEL_TOP  =
		ACC_W'(LEVEL_CAP * LEVEL_STEP * (2 ** GAIN_FRAC_BITS));
	localparam logic [ACC_W-1:0] LEVEL_OUT  =
		ACC_W'((LEVEL_CAP + 1) * LEVEL_STEP * (2 ** GAIN_FRAC_BITS));

	localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(17920);

	typedef enum logic [1:0] {
		CFG_PID_MODE = 2'd0,
		CFG_KP       = 2'd1,
		CFG_KI       = 2'd2,
		CFG_KD       = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		MODE_INCR = 1'b0,
		MODE_POS  = 1'b1
	} pid_mode_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] diff;
		logic                     dir;
		logic [ERR_W-1:0]         mag;
	} wrap_t;

	typedef struct packed {
		logic signed [TERM_W-1:0]  tp;
		logic signed [INTEG_W-1:0] ti;
		logic signed [TERM_W-1:0]  td;
		logic                      take_abs;
		logic                      dir;
		logic [ERR_W-1:0]          mag;
	} terms_t;

	typedef struct packed {
		logic signed [PD_W-1:0] pp;
		logic signed [PI_W-1:0] pi;
		logic signed [PD_W-1:0] pd;
		logic                   take_abs;
		logic                   dir;
		logic [ERR_W-1:0]       mag;
	} prod_t;

	// servo angle for levels -5..5, indexed by level + 5
	function automatic logic [ERR_W-1:0] level_angle(input logic [IDX_W-1:0] idx);
		logic [ERR_W-1:0] a;
		case (idx)
			4'd0:    a = 8'd180;
			4'd1:    a = 8'd126;
			4'd2:    a = 8'd117;
			4'd3:    a = 8'd108;
			4'd4:    a = 8'd99;
			4'd5:    a = 8'd90;
			4'd6:    a = 8'd81;
			4'd7:    a = 8'd72;
			4'd8:    a = 8'd63;
			4'd9:    a = 8'd54;
			default: a = 8'd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/apss_wrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apss_wrap: heading fold and shortest-path wrap
// Folds both headings into 0..359 and turns target - current into an error
// magnitude of 0..180 and a turn direction.
// ----------------------------------------------------------------------------
module apss_wrap import apss_pkg::*; (
	input  logic [HEAD_W-1:0] current_heading,
	input  logic [HEAD_W-1:0] target_heading,
	output wrap_t             wrap
);

	localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] FULL_S = DIFF_W'(FULL_TURN);

	logic [HEAD_W-1:0]        cur;
	logic [HEAD_W-1:0]        tgt;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] mag;

	assign cur = (current_heading >= HEAD_W'(FULL_TURN)) ?
		current_heading - HEAD_W'(FULL_TURN) : current_heading;
	assign tgt = (target_heading >= HEAD_W'(FULL_TURN)) ?
		target_heading - HEAD_W'(FULL_TURN) : target_heading;
	assign diff = signed'({1'b0, tgt}) - signed'({1'b0, cur});

	always_comb begin
		wrap.diff = diff;
		if (diff > HALF_S) begin
			mag      = FULL_S - diff;
			wrap.dir = 1'b1;
		end else if (diff < 0 && diff >= -HALF_S) begin
			mag      = -diff;
			wrap.dir = 1'b1;
		end else if (diff < -HALF_S) begin
			mag      = FULL_S + diff;
			wrap.dir = 1'b0;
		end else begin
			mag      = diff;
			wrap.dir = 1'b0;
		end
		wrap.mag = mag[ERR_W-1:0];
	end

endmodule
`default_nettype wire

>>> rtl/core/apss_terms.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apss_terms: PID error history, integral and term selection
// Holds the last two errors and the integral, builds the three terms that
// the gains multiply and registers them.
// ----------------------------------------------------------------------------
module apss_terms import apss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ld,
	input  pid_mode_t mode,
	input  wrap_t     wrap_s1,
	output terms_t    terms_s2
);

	localparam logic signed [SUM_W-1:0] CLAMP_S = SUM_W'(INTEG_CLAMP);
	localparam logic signed [SUM_W-1:0] FLIP_S  = SUM_W'(FLIP_LIMIT);

	logic [ERR_W-1:0]          e1_q;
	logic [ERR_W-1:0]          e2_q;
	logic signed [INTEG_W-1:0] integ_q;

	logic signed [TERM_W-1:0]  mag_s;
	logic signed [TERM_W-1:0]  e1_s;
	logic signed [TERM_W-1:0]  e2_s;
	logic signed [TERM_W-1:0]  d1;
	logic signed [TERM_W-1:0]  d2;
	logic signed [SUM_W-1:0]   isum;
	logic signed [SUM_W-1:0]   iclamp;
	logic signed [SUM_W-1:0]   iflip;
	logic signed [INTEG_W-1:0] integ_nx;
	terms_t                    terms_d;

	assign mag_s = signed'({2'b00, wrap_s1.mag});
	assign e1_s  = signed'({2'b00, e1_q});
	assign e2_s  = signed'({2'b00, e2_q});
	assign d1    = mag_s - e1_s;
	assign d2    = mag_s - (e1_s <<< 1) + e2_s;

	// integral: add raw difference, clamp, then flip sign past the limit
	always_comb begin
		isum = SUM_W'(integ_q) + SUM_W'(wrap_s1.diff);
		if (isum > CLAMP_S)
			iclamp = CLAMP_S;
		else if (isum < -CLAMP_S)
			iclamp = -CLAMP_S;
		else
			iclamp = isum;
		iflip    = (iclamp > FLIP_S || iclamp < -FLIP_S) ? -iclamp : iclamp;
		integ_nx = iflip[INTEG_W-1:0];
	end

	always_comb begin
		terms_d.dir = wrap_s1.dir;
		terms_d.mag = wrap_s1.mag;
		if (mode == MODE_INCR) begin
			terms_d.tp       = d1;
			terms_d.ti       = INTEG_W'(mag_s);
			terms_d.td       = d2;
			terms_d.take_abs = 1'b0;
		end else begin
			terms_d.tp       = mag_s;
			terms_d.ti       = integ_nx;
			terms_d.td       = d1;
			terms_d.take_abs = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q    <= '0;
			e2_q    <= '0;
			integ_q <= '0;
		end else if (ld) begin
			e1_q <= wrap_s1.mag;
			if (mode == MODE_INCR)
				e2_q <= e1_q;
			else
				integ_q <= integ_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ld)
			terms_s2 <= terms_d;
	end

	ap_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= INTEG_W'(INTEG_CLAMP)) && (integ_q >= -INTEG_W'(INTEG_CLAMP)))
		else $error("integral outside clamp range");

	ap_e2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && mode == MODE_INCR) |=> (e2_q == $past(e1_q)))
		else $error("error history did not shift");

	ap_integ_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && mode == MODE_INCR) |=> $stable(integ_q))
		else $error("integral changed in incremental mode");

endmodule
`default_nettype wire

>>> rtl/core/apss_mult.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apss_mult: gain multipliers
// Multiplies the three PID terms by their Q8.8 gains and registers the
// products.
// ----------------------------------------------------------------------------
module apss_mult import apss_pkg::*; (
	input  logic              clk,
	input  logic              ld,
	input  logic [GAIN_W-1:0] kp,
	input  logic [GAIN_W-1:0] ki,
	input  logic [GAIN_W-1:0] kd,
	input  terms_t            terms_s2,
	output prod_t             prod_s3
);

	prod_t prod_d;

	always_comb begin
		prod_d.pp       = PD_W'(signed'({1'b0, kp})) * PD_W'(terms_s2.tp);
		prod_d.pi       = PI_W'(signed'({1'b0, ki})) * PI_W'(terms_s2.ti);
		prod_d.pd       = PD_W'(signed'({1'b0, kd})) * PD_W'(terms_s2.td);
		prod_d.take_abs = terms_s2.take_abs;
		prod_d.dir      = terms_s2.dir;
		prod_d.mag      = terms_s2.mag;
	end

	always_ff @(posedge clk) begin
		if (ld)
			prod_s3 <= prod_d;
	end

endmodule
`default_nettype wire

>>> rtl/core/apss_quant.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apss_quant: level quantizer and servo table
// Sums the products, quantizes to a signed level and looks up the servo
// angle; levels outside the table keep the last angle.
// ----------------------------------------------------------------------------
module apss_quant import apss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ld,
	input  prod_t            prod_s3,
	output logic [ERR_W-1:0] servo_angle,
	output logic             turn_direction,
	output logic [ERR_W-1:0] wrapped_error
);

	logic signed [ACC_W-1:0] acc;
	logic [ACC_W-1:0]        amag;
	logic                    neg_eff;
	logic                    lvl_neg;
	logic                    in_rng;
	logic [LVL_W-1:0]        lvl;
	logic [IDX_W-1:0]        idx;
	logic [ERR_W-1:0]        servo_q;

	assign acc     = ACC_W'(prod_s3.pp) + ACC_W'(prod_s3.pi) + ACC_W'(prod_s3.pd);
	assign amag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
	// positional mode takes the absolute value, so only incremental goes negative
	assign neg_eff = acc[ACC_W-1] && !prod_s3.take_abs;

	always_comb begin
		lvl    = '0;
		in_rng = 1'b1;
		if (!neg_eff && amag > LEVEL_TOP) begin
			lvl = LVL_W'(LEVEL_CAP);
		end else begin
			for (int k = 1; k <= LEVEL_CAP; k++) begin
				if (amag >= ACC_W'(k) * LEVEL_UNIT)
					lvl = lvl + LVL_W'(1);
			end
			in_rng = (amag < LEVEL_OUT);
		end
	end

	// level sign: sum sign times turn direction
	assign lvl_neg = neg_eff ^ !prod_s3.dir;
	assign idx     = lvl_neg ? IDX_W'(LEVEL_CAP) - IDX_W'(lvl) : IDX_W'(LEVEL_CAP) + IDX_W'(lvl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			servo_q <= '0;
		else if (ld && in_rng)
			servo_q <= level_angle(idx);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			turn_direction <= prod_s3.dir;
			wrapped_error  <= prod_s3.mag;
		end
	end

	assign servo_angle = servo_q;

endmodule
`default_nettype wire

>>> rtl/core/angle_pid_servo_stepper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_pid_servo_stepper_unit: heading-hold PID servo stepper
// Takes a current and a target heading, forms the shortest-path error and
// turn direction, runs incremental or positional PID and maps the quantized
// level to a servo angle.
//
// Input channel in_valid/in_ready carries current_heading and target_heading;
// output channel out_valid/out_ready returns servo_angle, turn_direction and
// wrapped_error, one result per input transfer, in order.
// From input transfer to out_valid: wrap into the first register, error
// history and integral update into the term register, gain multipliers
// into the product register, sum, quantizer and table into the output
// register. One item per cycle is sustained while out_ready stays high.
// Each stage holds while the one after it is full and stalled, so a stalled
// receiver fills the pipe and in_ready drops only when all stages are full.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must write them
// only while idle, the block does not enforce it. Reset selects positional mode with
// Kp = 70.0, clears error history, integral and held servo angle, and empties the pipe.
// ----------------------------------------------------------------------------
module angle_pid_servo_stepper_unit import apss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [HEAD_W-1:0] current_heading,
	input  logic [HEAD_W-1:0] target_heading,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ERR_W-1:0]  servo_angle,
	output logic              turn_direction,
	output logic [ERR_W-1:0]  wrapped_error,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [GAIN_W-1:0] cfg_data
);

	pid_mode_t         mode_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;

	logic   v_s1, v_s2, v_s3, out_valid_q;
	logic   ld1, ld2, ld3, ld_out;
	wrap_t  wrap_d;
	wrap_t  wrap_s1;
	terms_t terms_s2;
	prod_t  prod_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_POS;
			kp_q   <= KP_RESET;
			ki_q   <= '0;
			kd_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PID_MODE: mode_q <= pid_mode_t'(cfg_data[0]);
				CFG_KP:       kp_q   <= cfg_data;
				CFG_KI:       ki_q   <= cfg_data;
				CFG_KD:       kd_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// pipeline advance: a stage loads when the one ahead is empty or moving
	assign ld_out   = v_s3 && (!out_valid_q || out_ready);
	assign ld3      = v_s2 && (!v_s3 || ld_out);
	assign ld2      = v_s1 && (!v_s2 || ld3);
	assign in_ready = !v_s1 || ld2;
	assign ld1      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= ld1 || (v_s1 && !ld2);
			v_s2        <= ld2 || (v_s2 && !ld3);
			v_s3        <= ld3 || (v_s3 && !ld_out);
			out_valid_q <= ld_out || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

	apss_wrap u_wrap (
		.current_heading (current_heading),
		.target_heading  (target_heading),
		.wrap            (wrap_d)
	);

	always_ff @(posedge clk) begin
		if (ld1)
			wrap_s1 <= wrap_d;
	end

	apss_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld2),
		.mode     (mode_q),
		.wrap_s1  (wrap_s1),
		.terms_s2 (terms_s2)
	);

	apss_mult u_mult (
		.clk      (clk),
		.ld       (ld3),
		.kp       (kp_q),
		.ki       (ki_q),
		.kd       (kd_q),
		.terms_s2 (terms_s2),
		.prod_s3  (prod_s3)
	);

	apss_quant u_quant (
		.clk            (clk),
		.arst_n         (arst_n),
		.ld             (ld_out),
		.prod_s3        (prod_s3),
		.servo_angle    (servo_angle),
		.turn_direction (turn_direction),
		.wrapped_error  (wrapped_error)
	);

	ap_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ld2) |=> (v_s1 && $stable(wrap_s1)))
		else $error("first stage lost its item while stalled");

	ap_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && out_valid_q))
		else $error("input stalled with room in the pipe");

	ap_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (wrapped_error <= ERR_W'(HALF_TURN)))
		else $error("wrapped error above half turn");

	ap_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wrapped_error == '0) |-> !turn_direction)
		else $error("zero error must turn in the negative direction");

endmodule
`default_nettype wire
